// File: hw/rtl/kto_pkg.sv
// Shared types, constants and helper functions for the keypad tone organ.
package kto_pkg;

  // Width of the tick counter used for debounce, release polls and tone half-periods.
  localparam int TICK_BITS = 16;
  localparam int KEY_COUNT = 16;
  localparam int KEY_BITS  = $clog2(KEY_COUNT);

  localparam logic [TICK_BITS-1:0] TICK_MASK = '1;
  localparam logic [31:0] TICK_MAX32 = 32'((64'd1 << TICK_BITS) - 64'd1);

  // Register widths.
  localparam int DEBOUNCE_BITS = 16;
  localparam int POLL_BITS     = 6;
  localparam int POLL_TICKS_BITS = 16;
  localparam int STEP_BITS     = 12;
  localparam int TOGGLE_BITS   = 10;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [POLL_BITS-1:0]   POLL_MAX   = '1;
  localparam logic [TOGGLE_BITS-1:0] TOGGLE_MAX = '1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE_TICKS     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE_POLL_STEPS = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE_POLL_TICKS = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TONE_STEP          = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOGGLE_COUNT       = 3'd4;

  // Reset values of the registers.
  localparam logic [DEBOUNCE_BITS-1:0]   RST_DEBOUNCE_TICKS     = 16'd1000;
  localparam logic [POLL_BITS-1:0]       RST_RELEASE_POLL_STEPS = 6'd50;
  localparam logic [POLL_TICKS_BITS-1:0] RST_RELEASE_POLL_TICKS = 16'd100;
  localparam logic [STEP_BITS-1:0]       RST_TONE_STEP          = 12'd10;
  localparam logic [TOGGLE_BITS-1:0]     RST_TOGGLE_COUNT       = 10'd450;

  localparam logic [3:0] NIBBLE_ALL_HIGH = 4'hF;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_REL_SCAN = 3'd2,
    PH_REL_FULL = 3'd3,
    PH_PLAY     = 3'd4
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] idx;
  } line_sel_t;

  // Position of the single low line in a nibble; not valid unless exactly one is low.
  function automatic line_sel_t one_low(input logic [3:0] nib);
    line_sel_t sel;
    sel = '0;
    unique case (nib)
      4'h7:    sel = '{valid: 1'b1, idx: 2'd0};
      4'hB:    sel = '{valid: 1'b1, idx: 2'd1};
      4'hD:    sel = '{valid: 1'b1, idx: 2'd2};
      4'hE:    sel = '{valid: 1'b1, idx: 2'd3};
      default: sel = '0;
    endcase
    return sel;
  endfunction

  // Saturate a limit to the largest count the tick counter holds.
  function automatic logic [TICK_BITS-1:0] clamp_ticks(input logic [31:0] v);
    if (v > TICK_MAX32) begin
      return TICK_MASK;
    end else begin
      return v[TICK_BITS-1:0];
    end
  endfunction

endpackage

// File: hw/rtl/keypad_tone_organ.sv
// Keypad tone organ: 4x4 key matrix scanner with a tone burst generator.
//
// Each request on the slave side is one time tick carrying the sensed row and column
// nibbles of a 4x4 key matrix (a low bit means a line is pulled down by a key). From
// idle a low row line starts a debounce wait of debounce_ticks ticks; if the press
// still holds, a pattern with exactly one low row and one low column is decoded into
// key row + 4 * column and flagged by key_strobe for that tick. A release wait of up
// to release_poll_steps polls, each release_poll_ticks + 1 ticks long, follows and
// ends early when the columns read all high; with no press, or a press gone after
// the debounce wait, it always runs in full.
// A decoded key then plays toggle_count toggles on tone_level with a half-period of
// tone_step * (key + 1) + 1 ticks. Every request yields exactly one result request.
// The block takes one request per clock while the result register is free or
// draining: the whole tick update is one pass of logic from the state registers into
// the result register, so a result is presented in the cycle after its request is
// accepted. The only arithmetic of note is the 12 x 5 bit half-period multiply.
// Configuration is written through cfg_we / cfg_index / cfg_data.
module keypad_tone_organ
  import kto_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // Configuration writes
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  // Tick input
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,   // [3:0] row_sense, [7:4] col_sense
  // Result output
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [7:0]               m_tdata    // [0] tone_level, [1] key_strobe,
                                              // [5:2] key_number, [6] busy_res, [7] zero
);

  // Configuration registers
  logic [DEBOUNCE_BITS-1:0]   debounce_ticks;
  logic [POLL_BITS-1:0]       release_poll_steps;
  logic [POLL_TICKS_BITS-1:0] release_poll_ticks;
  logic [STEP_BITS-1:0]       tone_step;
  logic [TOGGLE_BITS-1:0]     toggle_count;

  // Scanner state and its next values
  phase_t                 phase, phase_next;
  logic [TICK_BITS-1:0]   tick_count, tick_count_next;
  logic [POLL_BITS-1:0]   poll_count, poll_count_next;
  logic [TOGGLE_BITS-1:0] toggles_done, toggles_done_next;
  logic [KEY_BITS-1:0]    held_key, held_key_next;
  logic                   key_found, key_found_next;
  logic                   pin_level, pin_level_next;
  logic                   strobe;

  // Result register
  logic       out_valid;
  logic [7:0] out_data;
  logic [7:0] result;

  logic       in_accept;
  logic [3:0] rows;
  logic [3:0] cols;
  line_sel_t  row_sel;
  line_sel_t  col_sel;
  logic [TICK_BITS-1:0] debounce_lim;
  logic [TICK_BITS-1:0] poll_lim;
  logic [TICK_BITS-1:0] half_period;
  logic [STEP_BITS+KEY_BITS:0] half_raw;
  logic       release_done;

  assign rows = s_tdata[3:0];
  assign cols = s_tdata[7:4];

  // Accept a tick whenever the result register is free or drains this cycle.
  assign s_tready  = !out_valid || m_tready;
  assign in_accept = s_tvalid && s_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks     <= RST_DEBOUNCE_TICKS;
      release_poll_steps <= RST_RELEASE_POLL_STEPS;
      release_poll_ticks <= RST_RELEASE_POLL_TICKS;
      tone_step          <= RST_TONE_STEP;
      toggle_count       <= RST_TOGGLE_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE_TICKS:     debounce_ticks     <= cfg_data[DEBOUNCE_BITS-1:0];
        REG_RELEASE_POLL_STEPS: release_poll_steps <= cfg_data[POLL_BITS-1:0];
        REG_RELEASE_POLL_TICKS: release_poll_ticks <= cfg_data[POLL_TICKS_BITS-1:0];
        REG_TONE_STEP:          tone_step          <= cfg_data[STEP_BITS-1:0];
        REG_TOGGLE_COUNT:       toggle_count       <= cfg_data[TOGGLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Limits saturated to the tick counter range.
  assign row_sel      = one_low(rows);
  assign col_sel      = one_low(cols);
  assign debounce_lim = clamp_ticks(32'(debounce_ticks));
  assign poll_lim     = clamp_ticks(32'(release_poll_ticks));
  assign half_raw     = (STEP_BITS+KEY_BITS+1)'(tone_step)
                      * (STEP_BITS+KEY_BITS+1)'({1'b0, held_key} + (KEY_BITS+1)'(1));
  assign half_period  = clamp_ticks(32'(half_raw));

  // A release wait ends at the start of a poll once the polls are spent or, while
  // scanning, the columns read all high.
  assign release_done = (tick_count == '0)
                     && ((poll_count >= release_poll_steps)
                         || ((phase == PH_REL_SCAN) && (cols == NIBBLE_ALL_HIGH)));

  // Next state for one tick
  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    poll_count_next   = poll_count;
    toggles_done_next = toggles_done;
    held_key_next     = held_key;
    key_found_next    = key_found;
    pin_level_next    = pin_level;
    strobe            = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        key_found_next  = 1'b0;
        tick_count_next = '0;
        if (rows != NIBBLE_ALL_HIGH) begin
          phase_next = PH_DEBOUNCE;
        end else begin
          phase_next      = PH_REL_FULL;
          poll_count_next = '0;
        end
      end
      PH_DEBOUNCE: begin
        if (tick_count < debounce_lim) begin
          tick_count_next = tick_count + TICK_BITS'(1);
        end else begin
          tick_count_next = '0;
          poll_count_next = '0;
          if (rows != NIBBLE_ALL_HIGH) begin
            // Decode only a clean single-key pattern.
            if (row_sel.valid && col_sel.valid) begin
              held_key_next  = {col_sel.idx, row_sel.idx};
              key_found_next = 1'b1;
              strobe         = 1'b1;
            end else begin
              key_found_next = 1'b0;
            end
            phase_next = PH_REL_SCAN;
          end else begin
            key_found_next = 1'b0;
            phase_next     = PH_REL_FULL;
          end
        end
      end
      PH_REL_SCAN, PH_REL_FULL: begin
        if (release_done) begin
          tick_count_next = '0;
          if (key_found) begin
            phase_next        = PH_PLAY;
            toggles_done_next = '0;
            pin_level_next    = 1'b0;
          end else begin
            phase_next = PH_IDLE;
          end
        end else if (tick_count >= poll_lim) begin
          tick_count_next = '0;
          if (poll_count != POLL_MAX) begin
            poll_count_next = poll_count + POLL_BITS'(1);
          end
        end else begin
          tick_count_next = tick_count + TICK_BITS'(1);
        end
      end
      PH_PLAY: begin
        if ((tick_count == '0) && (toggles_done >= toggle_count)) begin
          // Burst over: drop the pin and go idle.
          pin_level_next = 1'b0;
          key_found_next = 1'b0;
          phase_next     = PH_IDLE;
        end else begin
          if (tick_count == '0) begin
            pin_level_next = !pin_level;
          end
          if (tick_count >= half_period) begin
            tick_count_next = '0;
            if (toggles_done != TOGGLE_MAX) begin
              toggles_done_next = toggles_done + TOGGLE_BITS'(1);
            end
          end else begin
            tick_count_next = tick_count + TICK_BITS'(1);
          end
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
        pin_level_next  = 1'b0;
      end
    endcase
  end

  // Result fields, taken from the state after the tick
  always_comb begin
    result    = '0;
    result[0] = (phase_next == PH_PLAY) ? pin_level_next : 1'b0;
    result[1] = strobe;
    result[5:2] = strobe ? held_key_next : '0;
    result[6] = (phase_next != PH_IDLE);
  end

  // Advance the scanner only on an accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count   <= '0;
      poll_count   <= '0;
      toggles_done <= '0;
      held_key     <= '0;
      key_found    <= 1'b0;
      pin_level    <= 1'b0;
    end else if (in_accept) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      poll_count   <= poll_count_next;
      toggles_done <= toggles_done_next;
      held_key     <= held_key_next;
      key_found    <= key_found_next;
      pin_level    <= pin_level_next;
    end
  end

  // Result register: load on accept, hold while stalled, clear once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= result;
    end
  end

endmodule

// File: dv/keypad_tone_organ_tb.sv
// Self-checking bench for the keypad tone organ: key-press tick streams in, tick results checked.
module keypad_tone_organ_tb;
  import kto_pkg::*;

  // One result request, packed as on m_tdata[6:0].
  typedef struct packed {
    logic       busy;
    logic [3:0] key;
    logic       strobe;
    logic       tone;
  } tick_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [7:0]               s_tdata = 8'hFF;   // [3:0] row_sense, [7:4] col_sense
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [7:0]               m_tdata;           // [0] tone, [1] strobe, [5:2] key, [6] busy

  keypad_tone_organ dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #10 clk = ~clk;

  // Mirror of the register file, updated as each write is driven.
  logic [15:0] cf_debounce   = RST_DEBOUNCE_TICKS;
  logic [5:0]  cf_polls      = RST_RELEASE_POLL_STEPS;
  logic [15:0] cf_poll_ticks = RST_RELEASE_POLL_TICKS;
  logic [11:0] cf_step       = RST_TONE_STEP;
  logic [9:0]  cf_toggles    = RST_TOGGLE_COUNT;

  // Scanner state as the organ should hold it.
  phase_t               ph    = PH_IDLE;
  logic [TICK_BITS-1:0] tcnt  = '0;
  logic [5:0]           pcnt  = '0;
  logic [9:0]           tdone = '0;
  logic [3:0]           hkey  = '0;
  logic                 kfound = 1'b0;
  logic                 pin   = 1'b0;

  logic [7:0]   pending_ticks[$];     // tick requests not yet offered
  tick_result_t pending_results[$];   // results owed by the organ, oldest first
  int           fault_count = 0;
  int           scan_ticks = 0;       // tick requests queued so far, filler included

  // Pacing knobs, changed only between phases.
  int gap_max = 0;
  int rx_mode = 0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_hold = 0;

  // Index of the single low line of a nibble, -1 for none or several.
  function automatic int low_line(input logic [3:0] nib);
    case (nib)
      4'h7:    return 0;
      4'hB:    return 1;
      4'hD:    return 2;
      4'hE:    return 3;
      default: return -1;
    endcase
  endfunction

  // Advance the scanner by one tick and return what the organ should report for it.
  function automatic tick_result_t organ_tick(input logic [3:0] rows, input logic [3:0] cols);
    tick_result_t res;
    int           r_idx;
    int           c_idx;
    int unsigned  half;
    res = '0;
    case (ph)
      PH_IDLE: begin
        kfound = 1'b0;
        tcnt = '0;
        if (rows != NIBBLE_ALL_HIGH) begin
          ph = PH_DEBOUNCE;
        end else begin
          // no press: sit out a full release wait anyway
          ph = PH_REL_FULL;
          pcnt = '0;
        end
      end
      PH_DEBOUNCE: begin
        if (tcnt < cf_debounce) begin
          tcnt = tcnt + 1'b1;
        end else begin
          r_idx = low_line(rows);
          c_idx = low_line(cols);
          tcnt = '0;
          pcnt = '0;
          kfound = 1'b0;
          if (rows == NIBBLE_ALL_HIGH) begin
            // press vanished during debounce
            ph = PH_REL_FULL;
          end else begin
            // several keys down leaves no key, but the scan still waits for release
            if (r_idx >= 0 && c_idx >= 0) begin
              hkey = 4'(r_idx + 4 * c_idx);
              kfound = 1'b1;
              res.strobe = 1'b1;
            end
            ph = PH_REL_SCAN;
          end
        end
      end
      PH_REL_SCAN, PH_REL_FULL: begin
        // columns are only looked at when a poll starts
        if (tcnt == '0 &&
            (pcnt >= cf_polls || (ph == PH_REL_SCAN && cols == NIBBLE_ALL_HIGH))) begin
          tcnt = '0;
          if (kfound) begin
            ph = PH_PLAY;
            tdone = '0;
            pin = 1'b0;
          end else begin
            ph = PH_IDLE;
          end
        end else if (tcnt >= cf_poll_ticks) begin
          tcnt = '0;
          if (pcnt != POLL_MAX) pcnt = pcnt + 1'b1;
        end else begin
          tcnt = tcnt + 1'b1;
        end
      end
      PH_PLAY: begin
        half = int'(cf_step) * (int'(hkey) + 1);
        if (half > int'(TICK_MASK)) half = TICK_MASK;
        if (tcnt == '0 && tdone >= cf_toggles) begin
          // burst over: drop the pin whatever the toggle parity
          pin = 1'b0;
          kfound = 1'b0;
          ph = PH_IDLE;
        end else begin
          if (tcnt == '0) pin = ~pin;
          if (tcnt >= half) begin
            tcnt = '0;
            if (tdone != TOGGLE_MAX) tdone = tdone + 1'b1;
          end else begin
            tcnt = tcnt + 1'b1;
          end
        end
      end
      default: begin
        ph = PH_IDLE;
        tcnt = '0;
        pin = 1'b0;
      end
    endcase
    res.tone = (ph == PH_PLAY) ? pin : 1'b0;
    res.key  = res.strobe ? hkey : 4'd0;
    res.busy = (ph != PH_IDLE);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offer queued ticks in bursts, with random gaps between bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_ticks.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_ticks.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: mode 0 never stalls, mode 1 stalls often and briefly,
  // mode 2 rarely but for long stretches.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || rx_mode == 0) begin
      m_tready <= 1'b1;
      rx_hold <= 0;
    end else if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(99, 0) < ((rx_mode == 1) ? 30 : 6))
        rx_hold <= $urandom_range((rx_mode == 1) ? 2 : 15, 1);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result request against the oldest expectation, then
  // predict the result of any tick request accepted at this edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    tick_result_t want;
    tick_result_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = tick_result_t'(m_tdata[6:0]);
        if (pending_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("result %h at %0t with nothing expected", m_tdata, $time);
        end else begin
          want = pending_results.pop_front();
          if (got.tone !== want.tone || got.strobe !== want.strobe ||
              got.key !== want.key || got.busy !== want.busy || m_tdata[7] !== 1'b0) begin
            fault_count++;
            if (fault_count <= 10)
              $display({"mismatch at %0t: expected tone %0d strobe %0d key %0d busy %0d,",
                        " got tone %0d strobe %0d key %0d busy %0d pad %0d"},
                       $time, want.tone, want.strobe, want.key, want.busy,
                       got.tone, got.strobe, got.key, got.busy, m_tdata[7]);
          end
        end
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(organ_tick(s_tdata[3:0], s_tdata[7:4]));
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_tick(input logic [3:0] rows, input logic [3:0] cols);
    pending_ticks.push_back({cols, rows});
    scan_ticks++;
  endtask

  // Ticks of a full release wait under the current settings.
  function automatic int full_wait();
    return int'(cf_polls) * (int'(cf_poll_ticks) + 1) + 1;
  endfunction

  // One press: initial detect, debounce, the check tick, a held stretch, release,
  // then filler for the note and the idle release wait. Lengths follow the
  // current settings; being a little off only shifts where the next press lands.
  task automatic queue_keypress(input logic [3:0] rp, input logic [3:0] cp, input bit holds);
    int          n;
    int          hold;
    int          key;
    int unsigned half;
    add_tick(rp, cp);
    for (n = 0; n < int'(cf_debounce); n++) begin
      if ($urandom_range(9, 0) < 7) add_tick(rp, cp);
      else add_tick(4'($urandom), 4'($urandom));
    end
    if (holds) add_tick(rp, cp);
    else add_tick(NIBBLE_ALL_HIGH, 4'($urandom));
    hold = $urandom_range((full_wait() < 8) ? full_wait() : 8, 0);
    for (n = 0; n < hold; n++) add_tick(rp, cp);
    for (n = $urandom_range(3, 1); n > 0; n--) add_tick(NIBBLE_ALL_HIGH, NIBBLE_ALL_HIGH);
    if (holds && low_line(rp) >= 0 && low_line(cp) >= 0) begin
      key = low_line(rp) + 4 * low_line(cp);
      half = int'(cf_step) * (key + 1);
      for (n = 0; n < int'(cf_toggles) * (int'(half) + 1); n++)
        add_tick(NIBBLE_ALL_HIGH, 4'($urandom));
    end
    for (n = 0; n < full_wait(); n++) add_tick(NIBBLE_ALL_HIGH, NIBBLE_ALL_HIGH);
  endtask

  // Mostly clean single-key presses, the rest chords, bounces, quiet and noise.
  task automatic queue_playing(input int target);
    int         goal;
    int         kind;
    int         n;
    logic [3:0] rp;
    logic [3:0] cp;
    goal = scan_ticks + target;
    while (scan_ticks < goal) begin
      kind = $urandom_range(99, 0);
      rp = 4'hF ^ (4'h8 >> $urandom_range(3, 0));
      cp = 4'hF ^ (4'h8 >> $urandom_range(3, 0));
      if (kind < 62) begin
        queue_keypress(rp, cp, 1'b1);
      end else if (kind < 76) begin
        // several keys down on rows, or columns without exactly one low line
        if ($urandom_range(1, 0)) begin
          do rp = 4'($urandom); while ($countones(~rp) < 2);
        end else begin
          do cp = 4'($urandom); while (low_line(cp) >= 0);
        end
        queue_keypress(rp, cp, 1'b1);
      end else if (kind < 85) begin
        queue_keypress(rp, cp, 1'b0);
      end else if (kind < 93) begin
        for (n = $urandom_range(12, 1); n > 0; n--) add_tick(NIBBLE_ALL_HIGH, 4'($urandom));
      end else begin
        for (n = $urandom_range(6, 1); n > 0; n--) add_tick(4'($urandom), 4'($urandom));
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_DEBOUNCE_TICKS:     cf_debounce = val;
      REG_RELEASE_POLL_STEPS: cf_polls = val[5:0];
      REG_RELEASE_POLL_TICKS: cf_poll_ticks = val;
      REG_TONE_STEP:          cf_step = val[11:0];
      REG_TOGGLE_COUNT:       cf_toggles = val[9:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] deb, input logic [5:0] polls,
                                input logic [15:0] poll_t, input logic [11:0] step,
                                input logic [9:0] togg);
    write_reg(REG_DEBOUNCE_TICKS, deb);
    write_reg(REG_RELEASE_POLL_STEPS, 16'(polls));
    write_reg(REG_RELEASE_POLL_TICKS, poll_t);
    write_reg(REG_TONE_STEP, 16'(step));
    write_reg(REG_TOGGLE_COUNT, 16'(togg));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_pace(input int gap, input int rxm);
    gap_max <= gap;
    rx_mode <= rxm;
  endtask

  // Hold off until every request has come back, then leave a few spare cycles.
  task automatic wait_drained();
    while (pending_ticks.size() != 0 || s_tvalid || pending_results.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: far too slow to finish a press, so just a little noise.
    set_pace(3, 1);
    for (n = 0; n < 20; n++) add_tick(4'($urandom), 4'($urandom));
    wait_drained();

    // Directed: corner keys, chords on rows and columns, columns all high,
    // a press that lets go during debounce, quiet ticks, odd toggle count.
    apply_settings(16'd1, 6'd2, 16'd1, 12'd1, 10'd3);
    set_pace(0, 0);
    queue_keypress(4'h7, 4'h7, 1'b1);
    queue_keypress(4'hE, 4'hE, 1'b1);
    queue_keypress(4'h3, 4'hE, 1'b1);
    queue_keypress(4'hB, 4'h0, 1'b1);
    queue_keypress(4'hD, NIBBLE_ALL_HIGH, 1'b1);
    queue_keypress(4'hD, 4'hB, 1'b0);
    for (n = 0; n < 3; n++) add_tick(NIBBLE_ALL_HIGH, NIBBLE_ALL_HIGH);
    wait_drained();

    // Low extremes: no debounce, no release wait, zero step, no note at all.
    apply_settings(16'd0, 6'd0, 16'd0, 12'd0, 10'd0);
    set_pace(2, 1);
    queue_playing(60);
    wait_drained();

    // Zero step: the pin flips every tick of the burst.
    apply_settings(16'd0, 6'd1, 16'd0, 12'd0, 10'd40);
    set_pace(0, 0);
    queue_keypress(4'h7, 4'hB, 1'b1);
    queue_playing(20);
    wait_drained();

    // A wide step on the top key, then the bottom key, for a long half-period.
    apply_settings(16'd0, 6'd0, 16'd0, 12'd8, 10'd1);
    queue_keypress(4'hE, 4'hE, 1'b1);
    queue_keypress(4'h7, 4'h7, 1'b1);
    wait_drained();

    // Random small settings, with the odd phase at the poll-count ceiling.
    while (scan_ticks < 680) begin
      apply_settings(16'($urandom_range(6, 0)),
                     ($urandom_range(9, 0) == 0) ? 6'd63 : 6'($urandom_range(5, 0)),
                     16'($urandom_range(4, 0)), 12'($urandom_range(3, 0)),
                     10'($urandom_range(6, 0)));
      case ($urandom_range(3, 0))
        0:       set_pace(0, 0);
        1:       set_pace(2, 1);
        2:       set_pace(6, 2);
        default: set_pace(0, 2);
      endcase
      queue_playing(60);
      wait_drained();
    end

    // High extremes: the organ stays in a wait, but every register sees its top.
    apply_settings(16'd65535, 6'd63, 16'd65535, 12'd4095, 10'd1023);
    set_pace(1, 1);
    for (n = 0; n < 40; n++) add_tick(4'($urandom), 4'($urandom));
    wait_drained();

    fault_count += pending_results.size();
    if (fault_count == 0) begin
      $display("PASS keypad_tone_organ");
    end else begin
      $display("FAIL keypad_tone_organ");
    end
    $finish;
  end

  // Give up well beyond the slowest correct run.
  initial begin : watchdog
    #64_000_000;
    $display("FAIL keypad_tone_organ");
    $finish;
  end

endmodule
